@@ design/ttrr_pkg.sv @@
// shared types and constants for the thread table round robin scheduler
// no dependencies

package ttrr_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    localparam logic [1:0] ST_INVALID  = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;
    localparam logic [1:0] ST_BLOCKED  = 2'd2;
    localparam logic [1:0] ST_FINISHED = 2'd3;

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_YIELD  = 2'd1;
    localparam logic [1:0] ACT_JOIN   = 2'd2;
    localparam logic [1:0] ACT_EXIT   = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] target_slot;
    } req_word_t;

    typedef struct packed {
        logic [2:0] slot_id;
        logic       success;
        logic [2:0] running_slot;
    } rsp_word_t;

endpackage

@@ design/ttrr_ram.sv @@
// generic single write port ram with registered read
// no dependencies

module ttrr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/ttrr_slot_match.sv @@
// shared status compare unit: resolves the reset value of unwritten entries
// and compares the slot status with the wanted code; uses ttrr_pkg

module ttrr_slot_match (
    input  logic [1:0] rd_status,
    input  logic       entry_valid,
    input  logic       is_slot0,
    input  logic [1:0] want,
    output logic       hit
);

    logic [1:0] status;

    always_comb
    begin
        if (entry_valid)
        begin
            status = rd_status;
        end
        else if (is_slot0)
        begin
            status = ttrr_pkg::ST_ACTIVE;
        end
        else
        begin
            status = ttrr_pkg::ST_INVALID;
        end
        hit = (status == want);
    end

endmodule

@@ design/thread_table_round_robin_scheduler_unit.sv @@
// top level of the thread table round robin scheduler
// uses ttrr_pkg, ttrr_ram and ttrr_slot_match

// One request word in, one result word out. Slot status and joiner ids sit in two small
// rams with a valid bit per entry, so reset takes effect at once with no clearing pass.
// A sequencer walks the status ram one slot at a time through a single compare unit,
// each slot checked by a ram read, then a compare. Join goes from acceptance straight
// to the result state, exit with a joiner through a joiner ram read first, create scans
// slots 1 to SLOT_COUNT-1 and yield, or exit without a joiner, up to SLOT_COUNT slots.
// A new request is taken once the previous result sits in the output register.
module thread_table_round_robin_scheduler_unit #(
    parameter int SLOT_COUNT = ttrr_pkg::SLOT_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ttrr_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ttrr_pkg::rsp_word_t rsp
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE_RD,
        S_CREATE_CHK,
        S_YIELD_RD,
        S_YIELD_CHK,
        S_EXIT_JRD,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       res_id_reg, res_id_next;
    logic                res_ok_reg, res_ok_next;
    logic [SLOT_COUNT-1:0] svalid_reg, svalid_next;
    logic [SLOT_COUNT-1:0] jvalid_reg, jvalid_next;
    logic                rsp_valid_reg, rsp_valid_next;
    ttrr_pkg::rsp_word_t rsp_reg, rsp_next;

    logic          st_wr_en;
    logic [IW-1:0] st_wr_addr;
    logic [1:0]    st_wr_data;
    logic [1:0]    st_rd_data;
    logic          jn_wr_en;
    logic [IW-1:0] jn_wr_addr;
    logic [IW-1:0] jn_rd_data;
    logic [1:0]    want;
    logic          hit;
    logic [IW-1:0] target_idx;
    logic          target_ok;
    logic [IW-1:0] cur_inc;
    logic [IW-1:0] idx_inc;
    logic [IW+2:0] target_wide;
    logic [IW+2:0] res_id_wide;
    logic [IW+2:0] run_wide;

    ttrr_ram #(
        .WIDTH (2),
        .DEPTH (SLOT_COUNT)
    ) u_status_ram (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (idx_reg),
        .rd_data (st_rd_data)
    );

    ttrr_ram #(
        .WIDTH (IW),
        .DEPTH (SLOT_COUNT)
    ) u_joiner_ram (
        .clk     (clk),
        .wr_en   (jn_wr_en),
        .wr_addr (jn_wr_addr),
        .wr_data (cur_reg),
        .rd_addr (cur_reg),
        .rd_data (jn_rd_data)
    );

    ttrr_slot_match u_match (
        .rd_status   (st_rd_data),
        .entry_valid (svalid_reg[idx_reg]),
        .is_slot0    (idx_reg == '0),
        .want        (want),
        .hit         (hit)
    );

    assign target_wide = {{IW{1'b0}}, req.target_slot};
    assign target_idx  = target_wide[IW-1:0];
    assign target_ok   = (32'(req.target_slot) < SLOT_COUNT);
    assign cur_inc     = (cur_reg == IW'(SLOT_COUNT - 1)) ? '0 : cur_reg + 1'b1;
    assign idx_inc     = (idx_reg == IW'(SLOT_COUNT - 1)) ? '0 : idx_reg + 1'b1;
    assign want        = (state_reg == S_CREATE_CHK) ? ttrr_pkg::ST_INVALID
                                                     : ttrr_pkg::ST_ACTIVE;
    assign res_id_wide = {3'b000, res_id_reg};
    assign run_wide    = {3'b000, cur_reg};

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        res_id_next    = res_id_reg;
        res_ok_next    = res_ok_reg;
        svalid_next    = svalid_reg;
        jvalid_next    = jvalid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        st_wr_en       = 1'b0;
        st_wr_addr     = cur_reg;
        st_wr_data     = ttrr_pkg::ST_FINISHED;
        jn_wr_en       = 1'b0;
        jn_wr_addr     = target_idx;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_ok_next = 1'b0;
                    case (req.action)
                        ttrr_pkg::ACT_CREATE:
                        begin
                            idx_next   = IW'(1);
                            state_next = S_CREATE_RD;
                        end
                        ttrr_pkg::ACT_YIELD:
                        begin
                            idx_next   = cur_inc;
                            cnt_next   = CW'(1);
                            state_next = S_YIELD_RD;
                        end
                        ttrr_pkg::ACT_JOIN:
                        begin
                            res_id_next = cur_reg;
                            if (target_ok)
                            begin
                                st_wr_en             = 1'b1;
                                st_wr_data           = ttrr_pkg::ST_BLOCKED;
                                svalid_next[cur_reg] = 1'b1;
                                jn_wr_en             = 1'b1;
                                jvalid_next[target_idx] = 1'b1;
                                cur_next             = target_idx;
                                res_id_next          = target_idx;
                            end
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            st_wr_en             = 1'b1;
                            svalid_next[cur_reg] = 1'b1;
                            if (jvalid_reg[cur_reg])
                            begin
                                state_next = S_EXIT_JRD;
                            end
                            else
                            begin
                                idx_next   = cur_inc;
                                cnt_next   = CW'(1);
                                state_next = S_YIELD_RD;
                            end
                        end
                    endcase
                end
            end
            S_CREATE_RD:
            begin
                state_next = S_CREATE_CHK;
            end
            S_CREATE_CHK:
            begin
                if (hit)
                begin
                    st_wr_en             = 1'b1;
                    st_wr_addr           = idx_reg;
                    st_wr_data           = ttrr_pkg::ST_ACTIVE;
                    svalid_next[idx_reg] = 1'b1;
                    jvalid_next[idx_reg] = 1'b0;
                    res_id_next          = idx_reg;
                    res_ok_next          = 1'b1;
                    state_next           = S_RESP;
                end
                else if (idx_reg == IW'(SLOT_COUNT - 1))
                begin
                    res_id_next = '0;
                    res_ok_next = 1'b0;
                    state_next  = S_RESP;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_CREATE_RD;
                end
            end
            S_YIELD_RD:
            begin
                state_next = S_YIELD_CHK;
            end
            S_YIELD_CHK:
            begin
                if (hit)
                begin
                    cur_next    = idx_reg;
                    res_id_next = idx_reg;
                    res_ok_next = 1'b1;
                    state_next  = S_RESP;
                end
                else if (cnt_reg == CW'(SLOT_COUNT))
                begin
                    res_id_next = cur_reg;
                    res_ok_next = 1'b0;
                    state_next  = S_RESP;
                end
                else
                begin
                    idx_next   = idx_inc;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_YIELD_RD;
                end
            end
            S_EXIT_JRD:
            begin
                st_wr_en                = 1'b1;
                st_wr_addr              = jn_rd_data;
                st_wr_data              = ttrr_pkg::ST_ACTIVE;
                svalid_next[jn_rd_data] = 1'b1;
                cur_next                = jn_rd_data;
                res_id_next             = jn_rd_data;
                res_ok_next             = 1'b0;
                state_next              = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.slot_id      = res_id_wide[2:0];
                    rsp_next.success      = res_ok_reg;
                    rsp_next.running_slot = run_wide[2:0];
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            svalid_reg    <= '0;
            jvalid_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            svalid_reg    <= svalid_next;
            jvalid_reg    <= jvalid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_id_reg <= res_id_next;
        res_ok_reg <= res_ok_next;
        rsp_reg    <= rsp_next;
    end

endmodule

@@ dv/thread_table_round_robin_scheduler_unit_tb.sv @@
// testbench for the thread table round robin scheduler: directed and random requests,
// expected results worked out by a scheduler model of its own, random idling both sides
// depends on ttrr_pkg and thread_table_round_robin_scheduler_unit
`timescale 1ns / 1ps

module thread_table_round_robin_scheduler_unit_tb;

    localparam int SLOTS = ttrr_pkg::SLOT_COUNT_DEF;
    localparam int RANDOM_REQS = 700;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    ttrr_pkg::req_word_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    ttrr_pkg::rsp_word_t rsp;

    ttrr_pkg::req_word_t pending_reqs[$];
    ttrr_pkg::rsp_word_t expected_rsps[$];
    ttrr_pkg::rsp_word_t due_rsp;

    logic [1:0] thread_state [SLOTS];
    logic       joiner_set [SLOTS];
    logic [2:0] joiner_of [SLOTS];
    logic [2:0] running_now;

    int send_gap = 0;
    int rsp_hold = 0;
    bit long_hold_done = 1'b0;
    int words_checked = 0;
    int failures = 0;

    thread_table_round_robin_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void reset_thread_table();
        int k;
        for (k = 0; k < SLOTS; k++)
        begin
            thread_state[k] = ttrr_pkg::ST_INVALID;
            joiner_set[k] = 1'b0;
            joiner_of[k] = '0;
        end
        thread_state[0] = ttrr_pkg::ST_ACTIVE;
        running_now = '0;
    endfunction

    // running slot itself is looked at last
    function automatic logic rotate_to_active();
        int k;
        logic [2:0] s;
        for (k = 1; k <= SLOTS; k++)
        begin
            s = 3'((int'(running_now) + k) % SLOTS);
            if (thread_state[s] == ttrr_pkg::ST_ACTIVE)
            begin
                running_now = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic ttrr_pkg::rsp_word_t schedule_request(ttrr_pkg::req_word_t w);
        ttrr_pkg::rsp_word_t r;
        int k;
        logic found;
        r = '0;
        found = 1'b0;
        case (w.action)
            ttrr_pkg::ACT_CREATE:
            begin
                for (k = 1; k < SLOTS; k++)
                begin
                    if (!found && thread_state[k] == ttrr_pkg::ST_INVALID)
                    begin
                        thread_state[k] = ttrr_pkg::ST_ACTIVE;
                        joiner_set[k] = 1'b0;
                        joiner_of[k] = '0;
                        r.slot_id = 3'(k);
                        r.success = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            ttrr_pkg::ACT_YIELD:
            begin
                r.success = rotate_to_active();
                r.slot_id = running_now;
            end
            ttrr_pkg::ACT_JOIN:
            begin
                thread_state[running_now] = ttrr_pkg::ST_BLOCKED;
                joiner_set[w.target_slot] = 1'b1;
                joiner_of[w.target_slot] = running_now;
                running_now = w.target_slot;
                r.slot_id = running_now;
            end
            default:
            begin
                thread_state[running_now] = ttrr_pkg::ST_FINISHED;
                if (joiner_set[running_now])
                begin
                    running_now = joiner_of[running_now];
                    thread_state[running_now] = ttrr_pkg::ST_ACTIVE;
                end
                else
                    r.success = rotate_to_active();
                r.slot_id = running_now;
            end
        endcase
        r.running_slot = running_now;
        return r;
    endfunction

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic push_req(logic [1:0] action, logic [2:0] target);
        ttrr_pkg::req_word_t w;
        w.action = action;
        w.target_slot = target;
        pending_reqs.push_back(w);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap <= 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (send_gap != 0 || pending_reqs.size() == 0)
            begin
                req_valid <= 1'b0;
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                send_gap <= pick_gap((pending_reqs.size() / 100) % 4 == 1);
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_hold <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && words_checked >= 350)
        begin
            rsp_ready <= 1'b0;
            rsp_hold <= 300;
            long_hold_done <= 1'b1;
        end
        else if (rsp_hold != 0)
        begin
            rsp_ready <= 1'b0;
            rsp_hold <= rsp_hold - 1;
        end
        else if (rsp_valid && rsp_ready)
        begin
            rsp_ready <= 1'b0;
            rsp_hold <= pick_gap((words_checked / 120) % 3 == 2);
        end
        else
            rsp_ready <= 1'b1;
    end

    // word monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_rsps.push_back(schedule_request(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, got %h", $time, rsp);
                    failures++;
                end
                else
                begin
                    due_rsp = expected_rsps.pop_front();
                    check_field("slot_id", int'(due_rsp.slot_id), int'(rsp.slot_id));
                    check_field("success", int'(due_rsp.success), int'(rsp.success));
                    check_field("running_slot", int'(due_rsp.running_slot),
                                int'(rsp.running_slot));
                end
                words_checked++;
            end
        end
    end

    initial
    begin
        int k;
        int r;
        logic [1:0] action;
        reset_thread_table();

        // directed: full table, failed create, self join, kept joiner, exits
        push_req(ttrr_pkg::ACT_YIELD, 3'd0);
        for (k = 0; k < SLOTS; k++)
            push_req(ttrr_pkg::ACT_CREATE, 3'd7);
        push_req(ttrr_pkg::ACT_YIELD, 3'd5);
        push_req(ttrr_pkg::ACT_JOIN, 3'd7);
        push_req(ttrr_pkg::ACT_JOIN, 3'd7);
        push_req(ttrr_pkg::ACT_EXIT, 3'd0);
        push_req(ttrr_pkg::ACT_EXIT, 3'd7);
        push_req(ttrr_pkg::ACT_JOIN, 3'd0);
        push_req(ttrr_pkg::ACT_EXIT, 3'd2);
        push_req(ttrr_pkg::ACT_YIELD, 3'd1);
        push_req(ttrr_pkg::ACT_EXIT, 3'd4);
        push_req(ttrr_pkg::ACT_EXIT, 3'd6);
        push_req(ttrr_pkg::ACT_EXIT, 3'd3);
        push_req(ttrr_pkg::ACT_CREATE, 3'd0);
        push_req(ttrr_pkg::ACT_JOIN, 3'd3);
        push_req(ttrr_pkg::ACT_EXIT, 3'd5);
        push_req(ttrr_pkg::ACT_YIELD, 3'd7);

        for (k = 0; k < RANDOM_REQS; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                action = ttrr_pkg::ACT_CREATE;
            else if (r < 45)
                action = ttrr_pkg::ACT_YIELD;
            else if (r < 70)
                action = ttrr_pkg::ACT_JOIN;
            else
                action = ttrr_pkg::ACT_EXIT;
            push_req(action, 3'($urandom_range(0, 7)));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
